// File: rtl/core/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the positional list table: request and status
// codes, controller states, cell command group and stream field layout.
// ----------------------------------------------------------------------------
package plt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_LOCATE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic write;
        logic shift_up;
        logic shift_down;
        logic scan;
        logic token_start;
    } cell_cmd_t;

    // input transaction fields
    localparam int OP_W    = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int OP_LSB    = 0;
    localparam int POS_LSB   = OP_LSB + OP_W;
    localparam int VALUE_LSB = POS_LSB + POS_W;
    localparam int S_FIELDS_W = VALUE_LSB + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // result transaction fields
    localparam int STATUS_W  = 3;
    localparam int REMOVED_W = 32;
    localparam int FOUND_W   = 4;
    localparam int LENGTH_W  = 5;
    localparam int STATUS_LSB  = 0;
    localparam int REMOVED_LSB = STATUS_LSB + STATUS_W;
    localparam int FOUND_LSB   = REMOVED_LSB + REMOVED_W;
    localparam int LENGTH_LSB  = FOUND_LSB + FOUND_W;
    localparam int M_FIELDS_W  = LENGTH_LSB + LENGTH_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

// File: rtl/core/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell
// One slot of the list: holds an entry, loads it from the key or from either
// neighbour, and passes the search token on to the next slot.
// ----------------------------------------------------------------------------
module plt_cell #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int IDX_W         = 4,
    parameter int IDX           = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  plt_pkg::cell_cmd_t       cmd,
    input  logic [IDX_W-1:0]         sel_idx,
    input  logic [ELEMENT_WIDTH-1:0] key,
    input  logic [ELEMENT_WIDTH-1:0] left_entry,
    input  logic [ELEMENT_WIDTH-1:0] right_entry,
    input  logic                     token_in,
    output logic [ELEMENT_WIDTH-1:0] entry,
    output logic                     token_out,
    output logic                     hit,
    output logic [ELEMENT_WIDTH-1:0] tap
);
    import plt_pkg::*;

    logic [ELEMENT_WIDTH-1:0] entry_reg;
    logic [ELEMENT_WIDTH-1:0] entry_next;
    logic                     token_reg;
    logic                     token_next;
    logic                     here;
    logic                     above;

    assign here  = (IDX_W'(IDX) == sel_idx);
    assign above = (IDX_W'(IDX) > sel_idx);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.write && here)
        begin
            entry_next = key;
        end
        else if (cmd.shift_up && above)
        begin
            entry_next = left_entry;
        end
        else if (cmd.shift_down && (above || here))
        begin
            entry_next = right_entry;
        end
    end

    assign token_next = cmd.scan ? token_in : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            token_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            token_reg <= token_next;
        end
    end

    assign entry     = entry_reg;
    assign token_out = token_reg;
    assign hit       = token_reg && (entry_reg == key);
    assign tap       = here ? entry_reg : '0;

endmodule

// File: rtl/core/positional_list_table.sv
// ----------------------------------------------------------------------------
// positional_list_table
// Ordered list of up to CAPACITY entries held in a chain of cells, with
// insert, delete, update and locate requests over a stream interface.
// ----------------------------------------------------------------------------
// sequence: each request is registered on input, executed on the chain once the
//   result register is free, and its result is registered; a locate then walks
//   the chain one cell per cycle until a match or the last entry
// flow: a new request is accepted only in the idle state, after the last result is loaded
// reset: asynchronous, clears every entry, the length and all handshake state
module positional_list_table #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation[1:0], position[6:2], value[38:7]
    input  logic [plt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], removed_value[34:3], found_index[38:35], list_length[43:39]
    output logic [plt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import plt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    state_t                   state_reg;
    state_t                   state_next;
    op_t                      req_op_reg;
    logic [POS_W-1:0]         req_pos_reg;
    logic [ELEMENT_WIDTH-1:0] req_key_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         scan_reg;
    logic [IDX_W-1:0]         scan_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    logic [REMOVED_W-1:0]     out_removed_reg;
    logic [FOUND_W-1:0]       out_found_reg;
    logic [LENGTH_W-1:0]      out_length_reg;

    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         cnt_c;
    logic [IDX_W-1:0]         sel_idx;
    logic                     list_full;
    logic                     list_empty;
    logic                     pos_ok_ins;
    logic                     pos_ok;

    status_t                  ex_status;
    logic [CNT_W-1:0]         ex_count;
    logic                     ex_write;
    logic                     ex_up;
    logic                     ex_down;
    logic                     ex_scan;

    logic                     out_free;
    logic                     scan_last;
    logic                     hit_any;
    logic [ELEMENT_WIDTH-1:0] removed_sel;
    logic                     res_load;
    status_t                  res_status;
    logic [REMOVED_W-1:0]     res_removed;
    logic [FOUND_W-1:0]       res_found;
    cell_cmd_t                cmd;

    logic [ELEMENT_WIDTH-1:0] entry_bus [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] tap_bus   [CAPACITY];
    logic                     token_bus [CAPACITY];
    logic                     hit_bus   [CAPACITY];

    // request checks against the current length
    assign pos_c      = CMP_W'(req_pos_reg);
    assign cnt_c      = CMP_W'(count_reg);
    assign sel_idx    = IDX_W'(pos_c - CMP_W'(1));
    assign list_full  = (count_reg == CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign pos_ok_ins = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1));
    assign pos_ok     = (pos_c != '0) && (pos_c <= cnt_c);

    always_comb
    begin
        ex_status = ST_OK;
        ex_count  = count_reg;
        ex_write  = 1'b0;
        ex_up     = 1'b0;
        ex_down   = 1'b0;
        ex_scan   = 1'b0;
        unique case (req_op_reg)
            OP_INSERT:
            begin
                if (list_full)
                begin
                    ex_status = ST_FULL;
                end
                else if (!pos_ok_ins)
                begin
                    ex_status = ST_BADPOS;
                end
                else
                begin
                    ex_write = 1'b1;
                    ex_up    = 1'b1;
                    ex_count = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE, OP_UPDATE:
            begin
                if (list_empty)
                begin
                    ex_status = ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    ex_status = ST_BADPOS;
                end
                else if (req_op_reg == OP_DELETE)
                begin
                    ex_down  = 1'b1;
                    ex_count = count_reg - CNT_W'(1);
                end
                else
                begin
                    ex_write = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                if (list_empty)
                begin
                    ex_status = ST_EMPTY;
                end
                else
                begin
                    ex_scan = 1'b1;
                end
            end
            default:
            begin
                ex_status = ST_OK;
            end
        endcase
    end

    // gather from the chain: search hit and the entry under the position
    always_comb
    begin
        hit_any     = 1'b0;
        removed_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_any     = hit_any | hit_bus[i];
            removed_sel = removed_sel | tap_bus[i];
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ex_scan ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (hit_any || scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        s_tready        = 1'b0;
        cmd             = '0;
        res_load        = 1'b0;
        res_status      = ex_status;
        res_removed     = '0;
        res_found       = '0;
        count_next      = count_reg;
        scan_next       = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.write       = ex_write;
                    cmd.shift_up    = ex_up;
                    cmd.shift_down  = ex_down;
                    cmd.scan        = ex_scan;
                    cmd.token_start = ex_scan;
                    res_load        = !ex_scan;
                    count_next      = ex_count;
                    scan_next       = '0;
                    if (ex_down)
                    begin
                        res_removed = REMOVED_W'(removed_sel);
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan  = 1'b1;
                scan_next = scan_reg + IDX_W'(1);
                if (hit_any)
                begin
                    res_load   = 1'b1;
                    res_status = ST_OK;
                    res_found  = FOUND_W'(scan_reg);
                end
                else if (scan_last)
                begin
                    res_load   = 1'b1;
                    res_status = ST_NOTFOUND;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = res_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_op_reg  <= op_t'(s_tdata[OP_LSB +: OP_W]);
            req_pos_reg <= s_tdata[POS_LSB +: POS_W];
            req_key_reg <= ELEMENT_WIDTH'(s_tdata[VALUE_LSB +: VALUE_W]);
        end
        if (res_load)
        begin
            out_status_reg  <= res_status;
            out_removed_reg <= res_removed;
            out_found_reg   <= res_found;
            out_length_reg  <= LENGTH_W'(count_next);
        end
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_entry;
        logic [ELEMENT_WIDTH-1:0] right_entry;
        logic                     token_in;

        if (g == 0)
        begin : g_first
            assign left_entry = '0;
            assign token_in   = cmd.token_start;
        end
        else
        begin : g_inner
            assign left_entry = entry_bus[g-1];
            assign token_in   = token_bus[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_body
            assign right_entry = entry_bus[g+1];
        end

        plt_cell #(
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .IDX_W         (IDX_W),
            .IDX           (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .sel_idx     (sel_idx),
            .key         (req_key_reg),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .token_in    (token_in),
            .entry       (entry_bus[g]),
            .token_out   (token_bus[g]),
            .hit         (hit_bus[g]),
            .tap         (tap_bus[g])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_length_reg, out_found_reg,
                       out_removed_reg, out_status_reg};

endmodule

// File: rtl/core/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks of the positional list table result stream, attached to
// the top level by a bind statement.
// ----------------------------------------------------------------------------
module plt_checker #(
    parameter int CAPACITY = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [plt_pkg::M_TDATA_W-1:0] m_tdata
);
    import plt_pkg::*;

    logic [STATUS_W-1:0]  status;
    logic [REMOVED_W-1:0] removed_value;
    logic [FOUND_W-1:0]   found_index;
    logic [LENGTH_W-1:0]  list_length;

    assign status        = m_tdata[STATUS_LSB +: STATUS_W];
    assign removed_value = m_tdata[REMOVED_LSB +: REMOVED_W];
    assign found_index   = m_tdata[FOUND_LSB +: FOUND_W];
    assign list_length   = m_tdata[LENGTH_LSB +: LENGTH_W];

    // a stalled result transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a rejected request or a failed locate reports no removed entry and no index
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status != ST_OK) |-> (removed_value == '0) && (found_index == '0))
        else $error("error result carries data");

    // full is only reported at capacity
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == ST_FULL) |-> (list_length == LENGTH_W'(CAPACITY)))
        else $error("full reported below capacity");

    // empty is only reported on an empty list
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == ST_EMPTY) |-> (list_length == '0))
        else $error("empty reported on a non-empty list");

endmodule

bind positional_list_table plt_checker #(
    .CAPACITY (CAPACITY)
) u_plt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
